/* design/lorentzian_dos_accumulator_defines.svh */
// Assertion macros used by the checker file.
`ifndef LORENTZIAN_DOS_ACCUMULATOR_DEFINES_SVH
`define LORENTZIAN_DOS_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LDOS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed (same-cycle implication)");

// Next-cycle implication, disabled during reset.
`define LDOS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed (next-cycle implication)");

`endif

/* design/ldos_pkg.sv */
// Types and constants of the Lorentzian density of states accumulator.
package ldos_pkg;

  localparam int EnergyW  = 32;
  localparam int WidthW   = 31;
  localparam int ScaleW   = 40;
  localparam int DensityW = 63;
  localparam int SumW     = 63;
  localparam int DenW     = 65;
  localparam int QuoW     = 51;
  localparam int ProdW    = 64;
  localparam int AccW     = SumW + ScaleW;
  localparam int CfgDataW = 40;
  localparam int CfgIdxW  = 2;

  // One quotient bit per step; the term never exceeds 2^50.
  localparam int DivSteps = QuoW;
  localparam int DivCntW  = $clog2(DivSteps);

  localparam logic [EnergyW-1:0] EnergyReset = 32'd0;
  localparam logic [WidthW-1:0]  WidthReset  = 31'd671;
  localparam logic [ScaleW-1:0]  ScaleReset  = 40'd1093710;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ENERGY     = 2'd0,
    REG_BROADENING = 2'd1,
    REG_SCALE      = 2'd2
  } reg_index_t;

  // Operand pairs of the shared 32x32 multiplier.
  typedef enum logic [2:0] {
    MUL_MAG_SQ,
    MUL_WIDTH_SQ,
    MUL_P00,
    MUL_P01,
    MUL_P10,
    MUL_P11
  } mul_sel_t;

  // How the product register enters the final-product accumulator.
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD32,
    ACC_ADD64
  } acc_op_t;

  typedef struct packed {
    logic     capture;
    mul_sel_t mul_sel;
    logic     save_sq;
    logic     load_den;
    logic     div_step;
    logic     div_first;
    logic     add_term;
    acc_op_t  acc_op;
    logic     load_out;
  } ldos_cmd_t;

  typedef struct packed {
    logic last;
    logic out_busy;
  } ldos_status_t;

endpackage

/* design/ldos_if.sv */
// Stream interfaces: eigenvalue items in, density results out.
interface ldos_in_if;
  import ldos_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [EnergyW-1:0]  eigenvalue;
  logic                       half_weight;
  logic                       last;

  modport source (output valid, eigenvalue, half_weight, last, input ready);
  modport sink   (input valid, eigenvalue, half_weight, last, output ready);
endinterface

interface ldos_out_if;
  import ldos_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [DensityW-1:0]  density;
  logic                 saturated;

  modport source (output valid, density, saturated, input ready);
  modport sink   (input valid, density, saturated, output ready);
endinterface

/* design/lorentzian_dos_accumulator.sv */
// Top level of the Lorentzian-broadened density of states accumulator.
//
//   port     | dir | payload                         | transaction
//   ---------+-----+---------------------------------+--------------------------
//   items    | in  | eigenvalue, half_weight, last   | valid && ready
//   results  | out | density, saturated              | valid && ready
//   wr_*     | in  | wr_index, wr_data               | wr_en high at clock edge
//
// An item passes through capture, the two squares on the shared 32x32 multiplier, the
// denominator, the restoring divider and accumulation.
// An item with last then forms the four partial products and loads the output register.
// Reset (rst, synchronous) restores the register defaults and clears the sum.
// A result held in the output register does not block new items; only the next
// result waits for that register to empty.
module lorentzian_dos_accumulator (
  input  logic                          clk,
  input  logic                          rst,
  ldos_in_if.sink                       items,
  ldos_out_if.source                    results,
  input  logic                          wr_en,
  input  ldos_pkg::reg_index_t          wr_index,
  input  logic [ldos_pkg::CfgDataW-1:0] wr_data
);
  import ldos_pkg::*;

  ldos_cmd_t    cmd;
  ldos_status_t status;

  ldos_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (items.ready),
    .status   (status),
    .cmd      (cmd)
  );

  ldos_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .wr_en          (wr_en),
    .wr_index       (wr_index),
    .wr_data        (wr_data),
    .in_eigenvalue  (items.eigenvalue),
    .in_half_weight (items.half_weight),
    .in_last        (items.last),
    .out_ready      (results.ready),
    .out_valid      (results.valid),
    .out_density    (results.density),
    .out_saturated  (results.saturated),
    .cmd            (cmd),
    .status         (status)
  );

endmodule

/* design/ldos_datapath.sv */
// Datapath: config registers, shared multiplier, restoring divider, accumulator, output register.
module ldos_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  ldos_pkg::reg_index_t              wr_index,
  input  logic [ldos_pkg::CfgDataW-1:0]     wr_data,
  input  logic signed [ldos_pkg::EnergyW-1:0] in_eigenvalue,
  input  logic                              in_half_weight,
  input  logic                              in_last,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [ldos_pkg::DensityW-1:0]     out_density,
  output logic                              out_saturated,
  input  ldos_pkg::ldos_cmd_t               cmd,
  output ldos_pkg::ldos_status_t            status
);
  import ldos_pkg::*;

  logic [EnergyW-1:0] energy;
  logic [WidthW-1:0]  broadening;
  logic [ScaleW-1:0]  scale;

  logic [EnergyW-1:0] mag;
  logic               half;
  logic               last;

  logic [31:0]        op_a;
  logic [31:0]        op_b;
  logic [ProdW-1:0]   prod;
  logic [ProdW-1:0]   mag_sq;

  logic [DenW-1:0]    den;
  logic [DenW-1:0]    rem;
  logic [QuoW-1:0]    quo;

  logic [SumW-1:0]    term_sum;
  logic               overflow_seen;
  logic [AccW-1:0]    acc;

  logic [EnergyW:0]   diff;
  logic [EnergyW:0]   diff_abs;
  logic [DenW:0]      trial;
  logic [DenW:0]      trial_sub;
  logic               q_bit;
  logic [QuoW-1:0]    term;
  logic [SumW:0]      sum_next;

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      energy     <= EnergyReset;
      broadening <= WidthReset;
      scale      <= ScaleReset;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_ENERGY:     energy     <= wr_data[EnergyW-1:0];
        REG_BROADENING: broadening <= wr_data[WidthW-1:0];
        REG_SCALE:      scale      <= wr_data[ScaleW-1:0];
        default: ;
      endcase
    end
  end

  assign diff     = {energy[EnergyW-1], energy} - {in_eigenvalue[EnergyW-1], in_eigenvalue};
  assign diff_abs = diff[EnergyW] ? (~diff + 1'b1) : diff;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mag  <= diff_abs[EnergyW-1:0];
      half <= in_half_weight;
      last <= in_last;
    end
  end

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_MAG_SQ: begin
        op_a = mag;
        op_b = mag;
      end
      MUL_WIDTH_SQ: begin
        op_a = {1'b0, broadening};
        op_b = {1'b0, broadening};
      end
      MUL_P00: begin
        op_a = term_sum[31:0];
        op_b = scale[31:0];
      end
      MUL_P01: begin
        op_a = term_sum[31:0];
        op_b = {24'd0, scale[ScaleW-1:32]};
      end
      MUL_P10: begin
        op_a = {1'b0, term_sum[SumW-1:32]};
        op_b = scale[31:0];
      end
      MUL_P11: begin
        op_a = {1'b0, term_sum[SumW-1:32]};
        op_b = {24'd0, scale[ScaleW-1:32]};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
    if (cmd.save_sq) begin
      mag_sq <= prod;
    end
  end

  // Dividend is broadening * 2^50; start from its bits above the quotient field.
  assign trial     = {rem, cmd.div_first ? broadening[0] : 1'b0};
  assign trial_sub = trial - {1'b0, den};
  assign q_bit     = !trial_sub[DenW];

  always_ff @(posedge clk) begin
    if (cmd.load_den) begin
      den <= {1'b0, mag_sq} + {1'b0, prod};
      rem <= {{(DenW-WidthW+1){1'b0}}, broadening[WidthW-1:1]};
    end else if (cmd.div_step) begin
      rem <= q_bit ? trial_sub[DenW-1:0] : trial[DenW-1:0];
      quo <= {quo[QuoW-2:0], q_bit};
    end
  end

  // Zero broadening gives a zero term, also for a zero denominator.
  always_comb begin
    term = (broadening == '0) ? '0 : quo;
    if (half) begin
      term = term >> 1;
    end
  end
  assign sum_next = {1'b0, term_sum} + {{(SumW+1-QuoW){1'b0}}, term};

  // Product term_sum * scale is below 2^103, so the accumulator cannot overflow; only the term sum saturates.
  always_ff @(posedge clk) begin
    unique case (cmd.acc_op)
      ACC_HOLD:  acc <= acc;
      ACC_LOAD:  acc <= {{(AccW-ProdW){1'b0}}, prod};
      ACC_ADD32: acc <= acc + {{(AccW-ProdW-32){1'b0}}, prod, 32'd0};
      ACC_ADD64: acc <= acc + {prod[AccW-65:0], 64'd0};
      default:   acc <= acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      term_sum      <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.load_out) begin
      term_sum      <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.add_term) begin
      if (sum_next[SumW]) begin
        term_sum      <= '1;
        overflow_seen <= 1'b1;
      end else begin
        term_sum <= sum_next[SumW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_density   <= acc[AccW-1:ScaleW];
      out_saturated <= overflow_seen;
    end
  end

  assign status.last     = last;
  assign status.out_busy = out_valid && !out_ready;

endmodule

/* design/ldos_ctrl.sv */
// Controller: sequences capture, squares, division, accumulation and the final product.
module ldos_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  ldos_pkg::ldos_status_t status,
  output ldos_pkg::ldos_cmd_t    cmd
);
  import ldos_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ_MAG,
    S_SQ_WIDTH,
    S_DEN,
    S_DIV,
    S_TERM,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_MFIN,
    S_OUT
  } state_t;

  state_t             state;
  logic [DivCntW-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_ready <= 1'b1;
      cnt      <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state    <= S_SQ_MAG;
            in_ready <= 1'b0;
          end
        end
        S_SQ_MAG:   state <= S_SQ_WIDTH;
        S_SQ_WIDTH: state <= S_DEN;
        S_DEN: begin
          state <= S_DIV;
          cnt   <= '0;
        end
        S_DIV: begin
          if (cnt == DivCntW'(DivSteps - 1)) begin
            state <= S_TERM;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_TERM: begin
          if (status.last) begin
            state <= S_MUL0;
          end else begin
            state    <= S_IDLE;
            in_ready <= 1'b1;
          end
        end
        S_MUL0: state <= S_MUL1;
        S_MUL1: state <= S_MUL2;
        S_MUL2: state <= S_MUL3;
        S_MUL3: state <= S_MFIN;
        S_MFIN: state <= S_OUT;
        S_OUT: begin
          if (!status.out_busy) begin
            state    <= S_IDLE;
            in_ready <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.mul_sel   = MUL_MAG_SQ;
    cmd.acc_op    = ACC_HOLD;
    cmd.capture   = (state == S_IDLE) && in_valid;
    cmd.div_first = (cnt == '0);
    unique case (state)
      S_SQ_MAG:   cmd.mul_sel = MUL_MAG_SQ;
      S_SQ_WIDTH: begin
        cmd.mul_sel = MUL_WIDTH_SQ;
        cmd.save_sq = 1'b1;
      end
      S_DEN:  cmd.load_den = 1'b1;
      S_DIV:  cmd.div_step = 1'b1;
      S_TERM: cmd.add_term = 1'b1;
      S_MUL0: cmd.mul_sel  = MUL_P00;
      S_MUL1: begin
        cmd.mul_sel = MUL_P01;
        cmd.acc_op  = ACC_LOAD;
      end
      S_MUL2: begin
        cmd.mul_sel = MUL_P10;
        cmd.acc_op  = ACC_ADD32;
      end
      S_MUL3: begin
        cmd.mul_sel = MUL_P11;
        cmd.acc_op  = ACC_ADD32;
      end
      S_MFIN: cmd.acc_op   = ACC_ADD64;
      S_OUT:  cmd.load_out = !status.out_busy;
      default: ;
    endcase
  end

endmodule

/* design/ldos_checker.sv */
// Port-level checker for the accumulator, bound to the top level.
`include "lorentzian_dos_accumulator_defines.svh"

module ldos_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [ldos_pkg::DensityW-1:0] out_density,
  input logic                          out_saturated
);
  import ldos_pkg::*;

  logic in_fire;
  assign in_fire = in_valid && in_ready;

  `LDOS_ASSERT_IMPL(a_ready_after_reset, clk, rst, $fell(rst), in_ready)
  `LDOS_ASSERT_NEXT(a_busy_after_item, clk, rst, in_fire, !in_ready ##1 !in_ready ##1 !in_ready)
  `LDOS_ASSERT_IMPL(a_result_while_busy, clk, rst, $rose(out_valid), $past(!in_ready))
  `LDOS_ASSERT_NEXT(a_result_holds, clk, rst, out_valid && !out_ready, out_valid && $stable(out_density) && $stable(out_saturated))

endmodule

bind lorentzian_dos_accumulator ldos_checker u_ldos_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (items.valid),
  .in_ready      (items.ready),
  .out_valid     (results.valid),
  .out_ready     (results.ready),
  .out_density   (results.density),
  .out_saturated (results.saturated)
);
